// File: sv/cfr_pkg.sv
// Shared constants for the CAN fragment reassembler.
// No dependencies; used by can_fragment_reassembler.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int MAX_PACKET = 512;
  localparam int INDEX_BITS = 6;

  localparam int LEN_BITS  = $clog2(MAX_PACKET + 1);
  localparam int ROWS      = MAX_PACKET / 8;
  localparam int ROW_BITS  = $clog2(ROWS);
  localparam int LANES     = 8;

  // frame layout
  localparam int CTL_START_BIT = 7;
  localparam int CTL_END_BIT   = 6;
  localparam logic [3:0] DLC_MAX  = 4'd8;
  localparam logic [2:0] START_HDR = 3'd3;
  localparam logic [2:0] CONT_HDR  = 3'd1;

  // request function codes
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // register index (paddr[2])
  localparam logic REG_MATCH_ID = 1'b0;
  localparam logic REG_MIN_LEN  = 1'b1;

endpackage

// File: sv/can_fragment_reassembler.sv
// CAN fragment reassembler: rebuilds one packet from CAN frames into a banked
// byte store. Depends on cfr_pkg and cfr_ram.
// An accepted request passes the stage-1 register, then the output register.
// Throughput: one request per cycle while the output is not stalled; frame
// checks and the banked store write (8 byte banks, one byte per bank) finish
// in the accept cycle. Reset clears control state, valid flags and config
// registers; the packet store is not cleared.
`timescale 1ns / 1ps

module can_fragment_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [10:0] in_can_id,
  input  logic [3:0]  in_dlc,
  input  logic [63:0] in_frame_data,
  input  logic [5:0]  in_read_addr,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_pkt_len,
  output logic [63:0] out_read_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LB = cfr_pkg::LEN_BITS;
  localparam int RB = cfr_pkg::ROW_BITS;

  // config registers
  logic [10:0]   match_id_r;
  logic [LB-1:0] min_len_r;

  // packet state
  logic          busy_r,      busy_nxt;
  logic [15:0]   total_len_r, total_len_nxt;
  logic [LB-1:0] got_len_r,   got_len_nxt;
  logic [7:0]    next_frag_r, next_frag_nxt;

  // stage between accept and output
  logic          p1_valid_r;
  logic          p1_read_r;
  logic [1:0]    p1_status_r, p1_status_nxt;
  logic [LB-1:0] p1_len_r,    p1_len_nxt;
  logic          p1_adv;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [9:0]    out_len_r;
  logic [63:0]   out_data_r;

  logic in_acc;
  logic cfg_wr;

  // decode
  logic [7:0]    ctl;
  logic          is_start, is_end;
  logic          dlc_bad, id_ok;
  logic          start_err, len_err, cont_err;
  logic [15:0]   ann_len, tot;
  logic [LB-1:0] base_len, remaining, new_got;
  logic [2:0]    offset;
  logic [3:0]    chunk, eff_chunk;
  logic          over, surplus_nz, over_err, proceed, got_eq_tot;
  logic          frame_ok, wr_en;
  logic [LB:0]   surplus_start;

  // store banks
  logic [cfr_pkg::LANES-1:0] bank_we;
  logic [RB-1:0] bank_row [cfr_pkg::LANES];
  logic [7:0]    bank_wd  [cfr_pkg::LANES];
  logic [7:0]    bank_rd  [cfr_pkg::LANES];
  logic [63:0]   rd_word;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      cfr_pkg::REG_MATCH_ID: prdata = {21'd0, match_id_r};
      cfr_pkg::REG_MIN_LEN:  prdata = {{(32 - LB){1'b0}}, min_len_r};
      default:               prdata = '0;
    endcase
  end

  // output register takes stage 1 when empty or being drained
  assign p1_adv   = !out_valid_r || !out_stall;
  assign in_stall = p1_valid_r && !p1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign ctl      = in_frame_data[7:0];
  assign is_start = ctl[cfr_pkg::CTL_START_BIT];
  assign is_end   = ctl[cfr_pkg::CTL_END_BIT];
  assign dlc_bad  = (in_dlc == 4'd0) || (in_dlc > cfr_pkg::DLC_MAX);
  assign id_ok    = (in_can_id == match_id_r);
  assign ann_len  = in_frame_data[23:8];

  assign start_err = (ctl[cfr_pkg::INDEX_BITS-1:0] != '0) || (in_dlc < 4'(cfr_pkg::START_HDR));
  assign len_err   = (ann_len < 16'(min_len_r)) || (ann_len > 16'(cfr_pkg::MAX_PACKET));
  assign cont_err  = !busy_r || (next_frag_r != 8'(ctl[cfr_pkg::INDEX_BITS-1:0]));

  assign offset    = is_start ? cfr_pkg::START_HDR : cfr_pkg::CONT_HDR;
  assign base_len  = is_start ? '0 : got_len_r;
  assign tot       = is_start ? ann_len : total_len_r;
  assign chunk     = in_dlc - {1'b0, offset};
  assign remaining = tot[LB-1:0] - base_len;
  assign over      = LB'(chunk) > remaining;
  assign surplus_start = {1'b0, remaining} + (LB + 1)'(offset);

  // surplus bytes past the expected length must all be zero
  always_comb begin
    surplus_nz = 1'b0;
    for (int p = 1; p < 8; p++) begin
      if ((4'(p) < in_dlc) && ((LB + 1)'(p) >= surplus_start) &&
          (in_frame_data[p*8 +: 8] != 8'd0)) begin
        surplus_nz = 1'b1;
      end
    end
  end

  assign over_err   = over && (!is_end || surplus_nz);
  assign proceed    = (is_start ? (!start_err && !len_err) : !cont_err) && !over_err;
  assign eff_chunk  = over ? remaining[3:0] : chunk;
  assign new_got    = base_len + LB'(eff_chunk);
  assign got_eq_tot = (16'(new_got) == tot);
  assign frame_ok   = (in_func == cfr_pkg::FUNC_FRAME) && !dlc_bad && id_ok;
  assign wr_en      = in_acc && frame_ok && proceed;

  always_comb begin
    busy_nxt      = busy_r;
    total_len_nxt = total_len_r;
    got_len_nxt   = got_len_r;
    next_frag_nxt = next_frag_r;
    p1_status_nxt = cfr_pkg::ST_NONE;
    p1_len_nxt    = '0;
    if (in_func == cfr_pkg::FUNC_READ) begin
      p1_status_nxt = cfr_pkg::ST_NONE;
    end else if (dlc_bad) begin
      p1_status_nxt = cfr_pkg::ST_ERR;
    end else if (id_ok) begin
      busy_nxt = proceed && !is_end && !got_eq_tot;
      if (is_start) begin
        if (!start_err) begin
          total_len_nxt = ann_len;
          if (!len_err) begin
            next_frag_nxt = 8'd1;
            got_len_nxt   = over_err ? '0 : new_got;
          end
        end
      end else if (!cont_err) begin
        next_frag_nxt = next_frag_r + 8'd1;
        if (!over_err) begin
          got_len_nxt = new_got;
        end
      end
      if (proceed && is_end && got_eq_tot) begin
        p1_status_nxt = cfr_pkg::ST_DONE;
        p1_len_nxt    = new_got;
      end else if (proceed && !is_end && !got_eq_tot) begin
        p1_status_nxt = cfr_pkg::ST_NONE;
      end else begin
        p1_status_nxt = cfr_pkg::ST_ERR;
      end
    end
  end

  // byte lane routing: bank b takes store byte with address mod 8 == b
  always_comb begin
    logic [2:0] lane;
    logic [2:0] sel;
    for (int b = 0; b < cfr_pkg::LANES; b++) begin
      lane        = 3'(b) - base_len[2:0];
      sel         = lane + offset;
      bank_we[b]  = wr_en && ({1'b0, lane} < eff_chunk);
      bank_row[b] = base_len[RB+2:3] + RB'(3'(b) < base_len[2:0]);
      bank_wd[b]  = in_frame_data[{sel, 3'b000} +: 8];
    end
  end

  for (genvar g = 0; g < cfr_pkg::LANES; g++) begin : g_bank
    cfr_ram #(
      .WIDTH(8),
      .DEPTH(cfr_pkg::ROWS)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we[g]),
      .waddr(bank_row[g]),
      .wdata(bank_wd[g]),
      .re   (in_acc && (in_func == cfr_pkg::FUNC_READ)),
      .raddr(in_read_addr[RB-1:0]),
      .rdata(bank_rd[g])
    );
    assign rd_word[g*8 +: 8] = bank_rd[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_id_r  <= '0;
      min_len_r   <= LB'(4);
      busy_r      <= 1'b0;
      total_len_r <= '0;
      got_len_r   <= '0;
      next_frag_r <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          cfr_pkg::REG_MATCH_ID: match_id_r <= pwdata[10:0];
          cfr_pkg::REG_MIN_LEN:  min_len_r  <= pwdata[LB-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        busy_r      <= busy_nxt;
        total_len_r <= total_len_nxt;
        got_len_r   <= got_len_nxt;
        next_frag_r <= next_frag_nxt;
      end
      if (in_acc) begin
        p1_valid_r <= 1'b1;
      end else if (p1_adv) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_adv) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_read_r   <= (in_func == cfr_pkg::FUNC_READ);
      p1_status_r <= p1_status_nxt;
      p1_len_r    <= p1_len_nxt;
    end
    if (p1_adv && p1_valid_r) begin
      out_status_r <= p1_status_r;
      out_len_r    <= 10'(p1_len_r);
      out_data_r   <= p1_read_r ? rd_word : 64'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pkt_len   = out_len_r;
  assign out_read_data = out_data_r;

endmodule

// File: sv/cfr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/can_fragment_reassembler_test.sv
// Self-checking test of can_fragment_reassembler: frame and read requests with a
// scoreboard that predicts every result. Depends on cfr_pkg and the block's RTL.
`timescale 1ns / 1ps

module can_fragment_reassembler_test;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int INDEX_MASK  = (1 << cfr_pkg::INDEX_BITS) - 1;

  typedef struct packed {
    logic        func;
    logic [10:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic [5:0]  read_addr;
  } cfr_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  pkt_len;
    logic [63:0] read_data;
  } cfr_res_t;

  class reassembly_scoreboard_t;
    logic [10:0] match_id;
    logic [9:0]  min_len;
    bit          busy;
    logic [15:0] total_len;
    logic [9:0]  got_len;
    logic [7:0]  next_frag;
    logic [7:0]  store [cfr_pkg::MAX_PACKET];
    bit          written [cfr_pkg::MAX_PACKET];
    cfr_res_t    awaited [$];
    int          errors;

    function new();
      match_id  = '0;
      min_len   = 10'd4;
      busy      = 1'b0;
      total_len = '0;
      got_len   = '0;
      next_frag = '0;
      errors    = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_reg(logic sel, logic [31:0] value);
      if (sel == cfr_pkg::REG_MATCH_ID) match_id = value[10:0];
      else min_len = value[9:0];
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function bit word_ready(int w);
      for (int i = 0; i < 8; i++) if (!written[w * 8 + i]) return 1'b0;
      return 1'b1;
    endfunction

    function logic [7:0] lane(logic [63:0] d, int k);
      return d[(k & 7) * 8 +: 8];
    endfunction

    function logic [1:0] abandon();
      busy = 1'b0;
      return cfr_pkg::ST_ERR;
    endfunction

    // frame with the matching identifier and a legal dlc
    function logic [1:0] take_frame(cfr_req_t r, output logic [9:0] len);
      logic [7:0] ctl;
      int idx, offset, chunk, remaining, a;
      len = '0;
      ctl = lane(r.data, 0);
      idx = ctl & INDEX_MASK;
      if (ctl[cfr_pkg::CTL_START_BIT]) begin
        if (idx != 0 || r.dlc < cfr_pkg::START_HDR) return abandon();
        total_len = {lane(r.data, 2), lane(r.data, 1)};
        if (total_len < 16'(min_len) || total_len > 16'(cfr_pkg::MAX_PACKET))
          return abandon();
        got_len   = '0;
        next_frag = 8'd1;
        busy      = 1'b1;
        offset    = int'(cfr_pkg::START_HDR);
      end else begin
        if (!busy || idx != int'(next_frag)) return abandon();
        next_frag++;
        offset = int'(cfr_pkg::CONT_HDR);
      end
      chunk = int'(r.dlc) - offset;
      remaining = (total_len >= 16'(got_len)) ? int'(total_len) - int'(got_len) : 0;
      if (chunk > remaining) begin
        // surplus only allowed on the end frame, and must be zero
        if (!ctl[cfr_pkg::CTL_END_BIT]) return abandon();
        for (int i = remaining; i < chunk; i++)
          if (lane(r.data, offset + i) != 8'h00) return abandon();
        chunk = remaining;
      end
      for (int i = 0; i < chunk; i++) begin
        a = int'(got_len) + i;
        if (a < cfr_pkg::MAX_PACKET) begin
          store[a]   = lane(r.data, offset + i);
          written[a] = 1'b1;
        end
      end
      got_len = 10'(int'(got_len) + chunk);
      if (ctl[cfr_pkg::CTL_END_BIT]) begin
        if (16'(got_len) != total_len) return abandon();
        busy = 1'b0;
        len  = got_len;
        return cfr_pkg::ST_DONE;
      end
      if (16'(got_len) == total_len) return abandon();
      return cfr_pkg::ST_NONE;
    endfunction

    function void note(cfr_req_t r);
      cfr_res_t e;
      logic [9:0] len;
      int a;
      e = '0;
      if (r.func == cfr_pkg::FUNC_READ) begin
        for (int i = 0; i < 8; i++) begin
          a = int'(r.read_addr) * 8 + i;
          if (a < cfr_pkg::MAX_PACKET) e.read_data[i * 8 +: 8] = store[a];
        end
      end else if (r.dlc == 4'd0 || r.dlc > cfr_pkg::DLC_MAX) begin
        e.status = cfr_pkg::ST_ERR;
      end else if (r.can_id == match_id) begin
        e.status  = take_frame(r, len);
        e.pkt_len = len;
      end
      awaited.push_back(e);
    endfunction

    function void check(cfr_res_t got);
      cfr_res_t e;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result: status %0d len %0d data %h",
                       got.status, got.pkt_len, got.read_data));
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status || got.pkt_len !== e.pkt_len ||
          got.read_data !== e.read_data)
        flag($sformatf({"result mismatch: expected status %0d len %0d data %h, ",
                        "got status %0d len %0d data %h"},
                       e.status, e.pkt_len, e.read_data,
                       got.status, got.pkt_len, got.read_data));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = cfr_pkg::FUNC_FRAME;
  logic [10:0] in_can_id = '0;
  logic [3:0]  in_dlc = '0;
  logic [63:0] in_frame_data = '0;
  logic [5:0]  in_read_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_pkt_len;
  logic [63:0] out_read_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  reassembly_scoreboard_t sb = new();

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int snd_burst = 0;
  int hold_asked = 0;
  int quiet = 0;

  can_fragment_reassembler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_can_id(in_can_id), .in_dlc(in_dlc), .in_frame_data(in_frame_data),
    .in_read_addr(in_read_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_pkt_len(out_pkt_len), .out_read_data(out_read_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // no request moved on either channel or the register port for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("can_fragment_reassembler test failed");
      $finish;
    end
  end

  // result side: check, then choose next cycle's stall
  initial begin
    int hold_left;
    int hold_seen;
    int burst;
    hold_left = 0;
    hold_seen = 0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check({out_status, out_pkt_len, out_read_data});
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (burst > 0) burst--;
        else if ($urandom_range(0, 39) == 0) burst = $urandom_range(20, 60);
        out_stall <= (burst == 0 && $urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] ctl_byte(bit s, bit e, int idx);
    logic [7:0] c;
    c = 8'(idx & INDEX_MASK);
    c[cfr_pkg::CTL_START_BIT] = s;
    c[cfr_pkg::CTL_END_BIT]   = e;
    return c;
  endfunction

  function automatic cfr_req_t frame_req(logic [3:0] dlc, logic [63:0] data);
    cfr_req_t r;
    r.func      = cfr_pkg::FUNC_FRAME;
    r.can_id    = sb.match_id;
    r.dlc       = dlc;
    r.data      = data;
    r.read_addr = 6'($urandom);
    return r;
  endfunction

  function automatic cfr_req_t read_req(int w);
    cfr_req_t r;
    r.func      = cfr_pkg::FUNC_READ;
    r.can_id    = 11'($urandom);
    r.dlc       = 4'($urandom);
    r.data      = {$urandom, $urandom};
    r.read_addr = 6'(w);
    return r;
  endfunction

  // called on a rising-edge step; returns on the step of acceptance
  task automatic send(cfr_req_t r);
    if (snd_burst > 0) snd_burst--;
    else if ($urandom_range(0, 29) == 0) snd_burst = $urandom_range(10, 40);
    while (snd_burst == 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= r.func;
    in_can_id     <= r.can_id;
    in_dlc        <= r.dlc;
    in_frame_data <= r.data;
    in_read_addr  <= r.read_addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic sel, logic [31:0] value);
    logic [31:0] mask;
    mask = (sel == cfr_pkg::REG_MATCH_ID) ? 32'h7FF : 32'h3FF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== value)
      sb.flag($sformatf("register %0d read back %h, expected %h",
                        sel, prdata & mask, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(sel, value);
  endtask

  task automatic run_directed();
    cfr_req_t q [$];
    cfr_req_t r;
    q.push_back(frame_req(4'd0, {$urandom, $urandom}));
    q.push_back(frame_req(4'd15, {$urandom, $urandom}));
    q.push_back(frame_req(4'd9, {$urandom, $urandom}));
    r = frame_req(4'd8, {40'h0, 16'd16, ctl_byte(1, 0, 0)});
    r.can_id = ~sb.match_id;
    q.push_back(r);
    q.push_back(frame_req(4'd8, {56'h0, ctl_byte(0, 0, 1)}));           // continuation while idle
    q.push_back(frame_req(4'd8, {40'h0, 16'd16, ctl_byte(1, 0, 3)}));   // start with an index
    q.push_back(frame_req(4'd2, {40'h0, 16'd16, ctl_byte(1, 0, 0)}));   // start too short
    q.push_back(frame_req(4'd3, {40'h0, 16'd3, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {40'h0, 16'd513, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {40'hFF_FFFF_FFFF, 16'hFFFF, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {40'h55_4433_2211, 16'd16, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {56'hCC_BBAA_9988_7766, ctl_byte(0, 0, 1)}));
    q.push_back(frame_req(4'd5, {24'h12_3456, 32'h00FF_EEDD, ctl_byte(0, 1, 2)}));
    q.push_back(read_req(0));
    q.push_back(read_req(1));
    q.push_back(frame_req(4'd8, {40'hA1_A2A3_A4A5, 16'd10, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {56'hB1_B2B3_B4B5_B6B7, ctl_byte(0, 0, 2)}));  // skipped index
    q.push_back(frame_req(4'd8, {40'hC1_C2C3_C4C5, 16'd6, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {48'h0, 8'hC6, ctl_byte(0, 1, 1)}));    // zero padding, fine
    q.push_back(frame_req(4'd8, {40'hC1_C2C3_C4C5, 16'd6, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {32'h0, 8'h01, 8'h00, 8'hC6, ctl_byte(0, 1, 1)}));
    q.push_back(frame_req(4'd8, {40'hC1_C2C3_C4C5, 16'd6, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {48'h0, 8'hC6, ctl_byte(0, 0, 1)}));    // surplus, no end flag
    q.push_back(frame_req(4'd8, {40'hD1_D2D3_D4D5, 16'd5, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd7, {8'hEE, 32'hE1E2_E3E4, 16'd4, ctl_byte(1, 1, 0)}));
    q.push_back(frame_req(4'd8, {40'hF1_F2F3_F4F5, 16'd20, ctl_byte(1, 0, 0)}));
    q.push_back(frame_req(4'd8, {56'hF6_F7F8_F9FA_FBFC, ctl_byte(0, 1, 1)}));  // end too early
    q.push_back(read_req(0));
    foreach (q[i]) send(q[i]);
  endtask

  task automatic run_traffic(int n);
    cfr_req_t q [$];
    cfr_req_t r;
    int done_cnt, kind, len, got, k, offset, take, j, w;
    bit last;
    done_cnt = 0;
    while (done_cnt < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        // well-formed packet, sometimes spoilt in one frame
        if ($urandom_range(0, 19) == 0)
          len = $urandom_range(sb.min_len, cfr_pkg::MAX_PACKET);
        else len = sb.min_len + $urandom_range(0, 40);
        if (len > cfr_pkg::MAX_PACKET) len = cfr_pkg::MAX_PACKET;
        got = 0;
        k = 0;
        do begin
          r = frame_req(cfr_pkg::DLC_MAX, {$urandom, $urandom});
          offset = (k == 0) ? int'(cfr_pkg::START_HDR) : int'(cfr_pkg::CONT_HDR);
          if ($urandom_range(0, 2) == 0)
            r.dlc = 4'($urandom_range(offset, cfr_pkg::DLC_MAX));
          take = int'(r.dlc) - offset;
          if (take > len - got) take = len - got;
          last = (got + take == len);
          if (last && take < int'(r.dlc) - offset && $urandom_range(0, 1))
            r.dlc = 4'(offset + take);
          for (int i = offset + take; i < r.dlc; i++) r.data[i * 8 +: 8] = 8'h00;
          r.data[7:0] = ctl_byte(k == 0, last, k);
          if (k == 0) r.data[23:8] = 16'(len);
          q.push_back(r);
          got += take;
          k++;
        end while (!last);
        if ($urandom_range(0, 99) < 15) begin
          j = $urandom_range(0, q.size() - 1);
          case ($urandom_range(0, 4))
            0: q[j].data[$urandom_range(0, 7)] ^= 1'b1;
            1: q[j].dlc = 4'($urandom);
            2: q[j].data[$urandom_range(8, 63)] ^= 1'b1;
            3: q[j].can_id ^= 11'h1 << $urandom_range(0, 10);
            default: q.delete(j);
          endcase
        end
      end else if (kind < 82) begin
        // only words whose bytes have all been stored
        repeat ($urandom_range(1, 3)) begin
          for (int t = 0; t < 8; t++) begin
            w = $urandom_range(0, 63);
            if (sb.word_ready(w)) begin
              q.push_back(read_req(w));
              break;
            end
          end
        end
      end else begin
        r = frame_req(4'($urandom), {$urandom, $urandom});
        if ($urandom_range(0, 1)) r.can_id = 11'($urandom);
        q.push_back(r);
      end
      foreach (q[i]) begin
        send(q[i]);
        if (!(q[i].func == cfr_pkg::FUNC_FRAME && q[i].dlc != 4'd0 &&
              q[i].dlc <= cfr_pkg::DLC_MAX && q[i].can_id != sb.match_id))
          done_cnt++;
      end
      q.delete();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_write(cfr_pkg::REG_MATCH_ID, 32'h5A5);
    reg_write(cfr_pkg::REG_MIN_LEN, 32'd4);
    run_directed();
    settle();

    // sender idles a little, receiver a lot
    snd_idle_pct = 10;
    rcv_idle_pct = 83;
    reg_write(cfr_pkg::REG_MATCH_ID, 32'd2047);
    reg_write(cfr_pkg::REG_MIN_LEN, 32'd0);
    run_traffic(300);
    hold_asked++;
    run_traffic(300);
    settle();

    reg_write(cfr_pkg::REG_MATCH_ID, 32'd0);
    reg_write(cfr_pkg::REG_MIN_LEN, cfr_pkg::MAX_PACKET);
    run_traffic(60);
    settle();

    snd_idle_pct = 83;
    rcv_idle_pct = 10;
    reg_write(cfr_pkg::REG_MATCH_ID, $urandom_range(0, 2047));
    reg_write(cfr_pkg::REG_MIN_LEN, $urandom_range(1, 64));
    run_traffic(200);
    settle();
    run_traffic(200);
    settle();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    reg_write(cfr_pkg::REG_MATCH_ID, $urandom_range(0, 2047));
    reg_write(cfr_pkg::REG_MIN_LEN, 32'd4);
    run_traffic(550);
    settle();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("can_fragment_reassembler test passed");
    end else begin
      $display("can_fragment_reassembler test failed");
    end
    $finish;
  end

endmodule
